// ===== rtl/bilinear_upsample_2x_top_defines.svh =====
// Assertion macros shared by the bilinear 2x upsampler RTL.
`ifndef BILINEAR_UPSAMPLE_2X_TOP_DEFINES_SVH
`define BILINEAR_UPSAMPLE_2X_TOP_DEFINES_SVH

// Check a property on every aclk edge outside reset.
`define BU2X_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that a condition implies another in the same cycle.
`define BU2X_ASSERT_SAME(lbl, ante, cons, msg) `BU2X_ASSERT(lbl, (ante) |-> (cons), msg)

// Check that a condition implies another in the next cycle.
`define BU2X_ASSERT_NEXT(lbl, ante, cons, msg) `BU2X_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/bu2x_pkg.sv =====
// Package of the bilinear 2x upsampler: defaults, register indexes, quad kinds.
package bu2x_pkg;

    // Default sizes of the block
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int DEF_PIXEL_BITS = 8;

    // Register values after reset
    localparam int RESET_PIC_WIDTH  = 176;
    localparam int RESET_PIC_HEIGHT = 144;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_PIC_WIDTH  = 1'b0,
        REG_PIC_HEIGHT = 1'b1
    } cfg_reg_t;

    // Quad kinds a pixel can complete, in emission order
    localparam int Q_DIAG    = 0;  // quad up and left of the pixel
    localparam int Q_UP      = 1;  // quad above the pixel (last column)
    localparam int Q_LEFT    = 2;  // quad left of the pixel (last row)
    localparam int Q_SELF    = 3;  // quad of the pixel itself (last column and row)
    localparam int NUM_QUADS = 4;

    typedef logic [NUM_QUADS-1:0] quad_mask_t;

    // Round a bit count up to whole bytes
    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

endpackage

// ===== rtl/bilinear_upsample_2x_top.sv =====
// Top level of the streaming bilinear 2x upsampler.
//
// Takes source pixels in raster order and returns one 2x2 output quad per source position,
// one quad word per cycle unless m_tready stalls: the pixel, its mean with the right
// neighbor, its mean with the lower neighbor and the mean of four. A quad passes through
// the pixel stage registers and then the output register. Most pixels complete at most one
// quad and are taken at one per cycle unless the output stalls; a last-column or last-row
// pixel completes two quads and the last pixel of a picture four, so such a pixel holds the
// input while the single output register issues its quads. The previous row sits in a line
// store of MAX_WIDTH entries read once per accepted pixel; it needs no clearing after reset.
// Write pic_width and pic_height only while the block is idle.
module bilinear_upsample_2x_top
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT),
    localparam int WCFG_BITS = $clog2(MAX_WIDTH + 1),
    localparam int HCFG_BITS = $clog2(MAX_HEIGHT + 1),
    localparam int CFG_DATA_BITS = (WCFG_BITS > HCFG_BITS) ? WCFG_BITS : HCFG_BITS,
    localparam int S_DATA_BITS   = byte_round(PIXEL_BITS),
    localparam int M_FIELD_BITS  = COL_BITS + ROW_BITS + 4 * PIXEL_BITS,
    localparam int M_DATA_BITS   = byte_round(M_FIELD_BITS)
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // Configuration writes
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Source pixels
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [S_DATA_BITS-1:0]    s_tdata,   // pixel
    // Output quads
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [M_DATA_BITS-1:0]    m_tdata,   // quad_col, quad_row, top_left, top_right,
                                                 // bottom_left, bottom_right, zero fill
    output logic                      m_tlast    // run_last
);

    logic                  accept;
    logic [PIXEL_BITS-1:0] pixel;
    logic [COL_BITS-1:0]   st_col;
    logic [ROW_BITS-1:0]   st_row;
    logic [PIXEL_BITS-1:0] st_left;
    quad_mask_t            st_mask;
    logic [PIXEL_BITS-1:0] ram_rd;
    logic [COL_BITS-1:0]   quad_col;
    logic [ROW_BITS-1:0]   quad_row;
    logic [PIXEL_BITS-1:0] top_left;
    logic [PIXEL_BITS-1:0] top_right;
    logic [PIXEL_BITS-1:0] bottom_left;
    logic [PIXEL_BITS-1:0] bottom_right;

    assign pixel  = s_tdata[PIXEL_BITS-1:0];
    assign accept = s_tvalid && s_tready;

    // Counters, configuration and quad selection
    bu2x_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .pixel     (pixel),
        .st_col    (st_col),
        .st_row    (st_row),
        .st_left   (st_left),
        .st_mask   (st_mask)
    );

    // Line store: read the pixel above, replace it with the new one
    bu2x_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .aclk  (aclk),
        .we    (accept),
        .waddr (st_col),
        .wdata (pixel),
        .re    (accept),
        .raddr (st_col),
        .rdata (ram_rd)
    );

    // Quad averaging and output register
    bu2x_emit #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .pixel    (pixel),
        .st_col   (st_col),
        .st_row   (st_row),
        .st_left  (st_left),
        .st_mask  (st_mask),
        .ram_rd   (ram_rd),
        .s_ready  (s_tready),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .out_col  (quad_col),
        .out_row  (quad_row),
        .out_tl   (top_left),
        .out_tr   (top_right),
        .out_bl   (bottom_left),
        .out_br   (bottom_right),
        .out_last (m_tlast)
    );

    // Pack the quad word, first field lowest
    assign m_tdata = M_DATA_BITS'({bottom_right, bottom_left, top_right, top_left,
                                   quad_row, quad_col});

endmodule

// ===== rtl/bu2x_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bu2x_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write, and read the old contents of the addressed entry
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/bu2x_front.sv =====
// Front end: configuration registers, raster counters and quad selection per pixel.
`include "bilinear_upsample_2x_top_defines.svh"

module bu2x_front
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT),
    localparam int WCFG_BITS = $clog2(MAX_WIDTH + 1),
    localparam int HCFG_BITS = $clog2(MAX_HEIGHT + 1),
    localparam int CFG_DATA_BITS = (WCFG_BITS > HCFG_BITS) ? WCFG_BITS : HCFG_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      accept,
    input  logic [PIXEL_BITS-1:0]     pixel,
    output logic [COL_BITS-1:0]       st_col,
    output logic [ROW_BITS-1:0]       st_row,
    output logic [PIXEL_BITS-1:0]     st_left,
    output quad_mask_t                st_mask
);

    logic [WCFG_BITS-1:0]  pic_width_reg;
    logic [HCFG_BITS-1:0]  pic_height_reg;
    logic [COL_BITS-1:0]   col_reg;
    logic [COL_BITS-1:0]   col_next;
    logic [ROW_BITS-1:0]   row_reg;
    logic [ROW_BITS-1:0]   row_next;
    logic [PIXEL_BITS-1:0] left_reg;
    logic [WCFG_BITS-1:0]  eff_width;
    logic [HCFG_BITS-1:0]  eff_height;
    logic                  last_col;
    logic                  last_row;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pic_width_reg  <= WCFG_BITS'(RESET_PIC_WIDTH);
            pic_height_reg <= HCFG_BITS'(RESET_PIC_HEIGHT);
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PIC_WIDTH:  pic_width_reg  <= cfg_data[WCFG_BITS-1:0];
                REG_PIC_HEIGHT: pic_height_reg <= cfg_data[HCFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Clamp sizes: zero counts as one, oversize saturates
    always_comb begin
        if (pic_width_reg == '0) begin
            eff_width = WCFG_BITS'(1);
        end else if (pic_width_reg > WCFG_BITS'(MAX_WIDTH)) begin
            eff_width = WCFG_BITS'(MAX_WIDTH);
        end else begin
            eff_width = pic_width_reg;
        end
        if (pic_height_reg == '0) begin
            eff_height = HCFG_BITS'(1);
        end else if (pic_height_reg > HCFG_BITS'(MAX_HEIGHT)) begin
            eff_height = HCFG_BITS'(MAX_HEIGHT);
        end else begin
            eff_height = pic_height_reg;
        end
    end

    // A counter at or past the edge counts as the edge
    assign last_col = WCFG_BITS'(col_reg) >= (eff_width - WCFG_BITS'(1));
    assign last_row = HCFG_BITS'(row_reg) >= (eff_height - HCFG_BITS'(1));

    // Pick the quads this pixel completes
    always_comb begin
        st_mask         = '0;
        st_mask[Q_DIAG] = (col_reg != '0) && (row_reg != '0);
        st_mask[Q_UP]   = last_col && (row_reg != '0);
        st_mask[Q_LEFT] = last_row && (col_reg != '0);
        st_mask[Q_SELF] = last_col && last_row;
    end

    // Advance the raster position
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (last_col) begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_BITS'(1);
        end else begin
            col_next = col_reg + COL_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            left_reg <= '0;
        end else if (accept) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            left_reg <= pixel;
        end
    end

    assign st_col  = col_reg;
    assign st_row  = row_reg;
    assign st_left = left_reg;

    `BU2X_ASSERT(a_col_in_store, col_reg <= COL_BITS'(MAX_WIDTH - 1), "column beyond line store")
    `BU2X_ASSERT(a_row_in_range, row_reg <= ROW_BITS'(MAX_HEIGHT - 1), "row beyond height limit")
    `BU2X_ASSERT_NEXT(a_wrap_on_self, accept && st_mask[Q_SELF], (col_reg == '0) && (row_reg == '0), "no wrap after picture end")

endmodule

// ===== rtl/bu2x_emit.sv =====
// Quad stage: holds one pixel's pending quads, averages them and drives the output register.
`include "bilinear_upsample_2x_top_defines.svh"

module bu2x_emit
    import bu2x_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS,
    localparam int COL_BITS  = $clog2(MAX_WIDTH),
    localparam int ROW_BITS  = $clog2(MAX_HEIGHT)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  logic [PIXEL_BITS-1:0] pixel,
    input  logic [COL_BITS-1:0]   st_col,
    input  logic [ROW_BITS-1:0]   st_row,
    input  logic [PIXEL_BITS-1:0] st_left,
    input  quad_mask_t            st_mask,
    input  logic [PIXEL_BITS-1:0] ram_rd,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [COL_BITS-1:0]   out_col,
    output logic [ROW_BITS-1:0]   out_row,
    output logic [PIXEL_BITS-1:0] out_tl,
    output logic [PIXEL_BITS-1:0] out_tr,
    output logic [PIXEL_BITS-1:0] out_bl,
    output logic [PIXEL_BITS-1:0] out_br,
    output logic                  out_last
);

    // Pixel stage
    quad_mask_t            pend_reg;
    quad_mask_t            pend_next;
    logic [COL_BITS-1:0]   col_s_reg;
    logic [ROW_BITS-1:0]   row_s_reg;
    logic [PIXEL_BITS-1:0] pix_s_reg;
    logic [PIXEL_BITS-1:0] left_s_reg;
    logic [PIXEL_BITS-1:0] ul_s_reg;

    // Output register
    logic                  m_valid_reg;
    logic [COL_BITS-1:0]   out_col_reg;
    logic [ROW_BITS-1:0]   out_row_reg;
    logic [PIXEL_BITS-1:0] out_tl_reg;
    logic [PIXEL_BITS-1:0] out_tr_reg;
    logic [PIXEL_BITS-1:0] out_bl_reg;
    logic [PIXEL_BITS-1:0] out_br_reg;
    logic                  out_last_reg;

    quad_mask_t            issue_sel;
    quad_mask_t            pend_after;
    logic                  out_load;
    logic [PIXEL_BITS-1:0] up;
    logic [PIXEL_BITS-1:0] qa;
    logic [PIXEL_BITS-1:0] qb;
    logic [PIXEL_BITS-1:0] qc;
    logic [PIXEL_BITS-1:0] qd;
    logic [COL_BITS-1:0]   qcol;
    logic [ROW_BITS-1:0]   qrow;
    logic [PIXEL_BITS:0]   sum_ab;
    logic [PIXEL_BITS:0]   sum_ac;
    logic [PIXEL_BITS+1:0] sum_abcd;

    // Pixel above the staged one, read at accept
    assign up = ram_rd;

    // Issue the earliest pending quad when the output register frees up
    assign issue_sel  = pend_reg & (~pend_reg + quad_mask_t'(1));
    assign out_load   = (pend_reg != '0) && (!m_valid_reg || m_ready);
    assign pend_after = out_load ? (pend_reg & ~issue_sel) : pend_reg;
    assign s_ready    = (pend_after == '0);
    assign pend_next  = accept ? st_mask : pend_after;

    // Select corner pixels and position of the issued quad
    always_comb begin
        qa   = pix_s_reg;
        qb   = pix_s_reg;
        qc   = pix_s_reg;
        qd   = pix_s_reg;
        qcol = col_s_reg;
        qrow = row_s_reg;
        if (pend_reg[Q_DIAG]) begin
            qa   = ul_s_reg;
            qb   = up;
            qc   = left_s_reg;
            qd   = pix_s_reg;
            qcol = col_s_reg - COL_BITS'(1);
            qrow = row_s_reg - ROW_BITS'(1);
        end else if (pend_reg[Q_UP]) begin
            qa   = up;
            qb   = up;
            qc   = pix_s_reg;
            qd   = up;
            qrow = row_s_reg - ROW_BITS'(1);
        end else if (pend_reg[Q_LEFT]) begin
            qa   = left_s_reg;
            qb   = pix_s_reg;
            qc   = left_s_reg;
            qd   = left_s_reg;
            qcol = col_s_reg - COL_BITS'(1);
        end
    end

    // Truncated means
    assign sum_ab   = {1'b0, qa} + {1'b0, qb};
    assign sum_ac   = {1'b0, qa} + {1'b0, qc};
    assign sum_abcd = {2'b00, qa} + {2'b00, qb} + {2'b00, qc} + {2'b00, qd};

    // Hold the pending quads of the staged pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            col_s_reg  <= st_col;
            row_s_reg  <= st_row;
            pix_s_reg  <= pixel;
            left_s_reg <= st_left;
            ul_s_reg   <= ram_rd;
        end
    end

    // Output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_col_reg  <= qcol;
            out_row_reg  <= qrow;
            out_tl_reg   <= qa;
            out_tr_reg   <= sum_ab[PIXEL_BITS:1];
            out_bl_reg   <= sum_ac[PIXEL_BITS:1];
            out_br_reg   <= sum_abcd[PIXEL_BITS+1:2];
            out_last_reg <= (pend_after == '0);
        end
    end

    assign m_valid  = m_valid_reg;
    assign out_col  = out_col_reg;
    assign out_row  = out_row_reg;
    assign out_tl   = out_tl_reg;
    assign out_tr   = out_tr_reg;
    assign out_bl   = out_bl_reg;
    assign out_br   = out_br_reg;
    assign out_last = out_last_reg;

    `BU2X_ASSERT_NEXT(a_no_bubble, !m_valid_reg && (pend_reg != '0), m_valid_reg, "pending quad not issued")
    `BU2X_ASSERT_NEXT(a_stage_drained, out_load && (pend_after == '0) && !accept, !out_load, "quad issued from empty stage")
    `BU2X_ASSERT_NEXT(a_self_flat, out_load && issue_sel[Q_SELF], (out_tl_reg == out_br_reg) && (out_tr_reg == out_bl_reg), "corner quad not flat")
    `BU2X_ASSERT_SAME(a_accept_empty, accept, pend_after == '0, "pixel accepted over pending quads")

endmodule
